### rtl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared constants, types and twiddle/address helpers for the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

   localparam int LogMaxPoints = 6;
   localparam int MaxPoints    = 1 << LogMaxPoints;
   localparam int AddrBits     = LogMaxPoints;
   localparam int SampleBits   = 16;
   localparam int StoreBits    = 24;
   localparam int TwiddleBits  = 16;
   localparam int TwBits       = TwiddleBits + 1;   // holds +1.0 exactly
   localparam int RoundShift   = TwiddleBits - 1;
   localparam int ProdBits     = StoreBits + TwBits;
   localparam int CsrIdxBits   = 8;
   localparam int CsrDataBits  = 8;

   // register indexes
   localparam logic [CsrIdxBits-1:0] REG_INVERSE  = 8'd0;
   localparam logic [CsrIdxBits-1:0] REG_LOG_SIZE = 8'd1;
   localparam logic [CsrIdxBits-1:0] REG_CENTER   = 8'd2;

   typedef logic [AddrBits-1:0]        addr_type;
   typedef logic signed [StoreBits-1:0] store_type;
   typedef logic signed [TwBits-1:0]    tw_type;

   typedef struct packed {
      tw_type wr;
      tw_type wi;
   } twiddle_type;

   // controller to datapath commands
   typedef struct packed {
      logic      load_we;
      addr_type  load_addr;
      logic      rd_en;
      logic      rd_bank;
      addr_type  rd_addr_a;
      addr_type  rd_addr_b;
      logic      neg_a;
      logic      neg_b;
      logic      mul_en;
      logic      tw_en;
      logic      wr_p;
      logic      wr_q;
      logic      wr_bank;
      addr_type  wr_addr_p;
      addr_type  wr_addr_q;
      logic [4:0] tw_index;
      logic      inverse;
      logic      center;
      logic [2:0] log_size;
      logic      out_load;
      logic      out_last;
      logic      out_odd;
   } cmd_type;

   // round(32768 * cos(2*pi*k/64)), k = 0..16
   function automatic tw_type cos_q(input logic [4:0] k);
      tw_type c;
      case (k)
         5'd0:    c = 17'sd32768;
         5'd1:    c = 17'sd32610;
         5'd2:    c = 17'sd32138;
         5'd3:    c = 17'sd31357;
         5'd4:    c = 17'sd30274;
         5'd5:    c = 17'sd28899;
         5'd6:    c = 17'sd27246;
         5'd7:    c = 17'sd25330;
         5'd8:    c = 17'sd23170;
         5'd9:    c = 17'sd20788;
         5'd10:   c = 17'sd18205;
         5'd11:   c = 17'sd15447;
         5'd12:   c = 17'sd12540;
         5'd13:   c = 17'sd9512;
         5'd14:   c = 17'sd6393;
         5'd15:   c = 17'sd3212;
         default: c = 17'sd0;
      endcase
      return c;
   endfunction

   // W = cos - j*sin forward, conjugate for inverse
   function automatic twiddle_type twiddle(input logic [4:0] k, input logic inv);
      twiddle_type w;
      tw_type      c;
      tw_type      s;
      if (k <= 5'd16) begin
         c = cos_q(k);
         s = cos_q(5'(6'd16 - {1'b0, k}));
      end else begin
         c = -cos_q(5'(6'd32 - {1'b0, k}));
         s = cos_q(5'(k - 5'd16));
      end
      w.wr = c;
      w.wi = inv ? s : -s;
      return w;
   endfunction

   // reverse the low lg bits of an address
   function automatic addr_type bit_rev(input addr_type a, input logic [2:0] lg);
      addr_type r;
      for (int i = 0; i < AddrBits; i++) r[i] = a[AddrBits-1-i];
      return r >> (3'(AddrBits) - lg);
   endfunction

endpackage

### rtl/r2fft_req_if.sv
// ----------------------------------------------------------------------------
// r2fft_req_if
// Sample input channel: one complex sample per item.
// ----------------------------------------------------------------------------
interface r2fft_req_if;
   import r2fft_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SampleBits-1:0]  sample_real;
   logic signed [SampleBits-1:0]  sample_imag;
   modport source (output valid, output sample_real, output sample_imag, input ready);
   modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

### rtl/r2fft_rsp_if.sv
// ----------------------------------------------------------------------------
// r2fft_rsp_if
// Result channel: one transform bin per item.
// ----------------------------------------------------------------------------
interface r2fft_rsp_if;
   import r2fft_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [StoreBits-1:0]  bin_real;
   logic signed [StoreBits-1:0]  bin_imag;
   logic                         frame_last;
   modport source (output valid, output bin_real, output bin_imag, output frame_last,
                   input ready);
   modport sink   (input valid, input bin_real, input bin_imag, input frame_last,
                   output ready);
endinterface

### rtl/r2fft_csr_if.sv
// ----------------------------------------------------------------------------
// r2fft_csr_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface r2fft_csr_if;
   import r2fft_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CsrIdxBits-1:0]   index;
   logic [CsrDataBits-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/radix2_complex_fft.sv
// Sequence: after the last sample of a frame, (N/2)*log2(N) butterflies run, each
//   as read, multiply, round, low write and high write; then each result is
//   read and loaded into the result register once that register is free.
// Throughput: one sample per cycle while loading; no sample is taken while a
//   frame is transformed or unloaded, and all butterflies share a single unit.
// Reset (synchronous, active high): empty frame, forward, log_size 6, no
//   centering; sample banks are not cleared.
// ----------------------------------------------------------------------------
// radix2_complex_fft
// Streaming radix-2 decimation-in-time complex FFT, up to 64 points.
// ----------------------------------------------------------------------------
module radix2_complex_fft import r2fft_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   r2fft_req_if.sink       req_chan,
   r2fft_rsp_if.source     rsp_chan,
   r2fft_csr_if.sink       csr_chan
);

   cmd_type cmd;
   logic    out_free;

   assign csr_chan.ready = 1'b1;

   r2fft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   r2fft_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample_real (req_chan.sample_real),
      .sample_imag (req_chan.sample_imag),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .bin_real    (rsp_chan.bin_real),
      .bin_imag    (rsp_chan.bin_imag),
      .frame_last  (rsp_chan.frame_last),
      .out_free    (out_free)
   );

   // the low write of a butterfly is always followed by the high write
   a_write_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_p |=> cmd.wr_q) else $error("butterfly write pair broken");

   // no sample is taken while the butterfly unit is busy
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !(cmd.mul_en || cmd.tw_en || cmd.wr_p || cmd.wr_q))
      else $error("load during transform");

   // a result is only loaded into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result overwritten");

endmodule

### rtl/r2fft_ctrl.sv
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Sequencer: load counting, butterfly stage/index walk, unload, registers.
// ----------------------------------------------------------------------------
module r2fft_ctrl import r2fft_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    csr_valid,
   input  logic [CsrIdxBits-1:0]   csr_index,
   input  logic [CsrDataBits-1:0]  csr_data,
   input  logic                    out_free,
   output cmd_type                 cmd
);

   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_TW   = 3'd3;
   localparam logic [2:0] S_WP   = 3'd4;
   localparam logic [2:0] S_WQ   = 3'd5;
   localparam logic [2:0] S_ORD  = 3'd6;
   localparam logic [2:0] S_OLD  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [6:0] count_ff, count_in;
   logic [2:0] stage_ff, stage_in;
   logic [4:0] bfly_ff, bfly_in;
   addr_type   oidx_ff, oidx_in;
   logic       inverse_ff, center_ff;
   logic [2:0] log_ff;

   logic [2:0] lg;
   logic [6:0] n;
   logic [5:0] half;
   logic [4:0] low_mask, q;
   addr_type   p, p2, ra, rb;
   logic       accept, bfly_last, stage_last, out_last;

   // effective size
   always_comb begin
      if (log_ff == 3'd0) lg = 3'd1;
      else if (log_ff > 3'(LogMaxPoints)) lg = 3'(LogMaxPoints);
      else lg = log_ff;
   end
   assign n = 7'd1 << lg;

   // butterfly addresses for the current stage and index
   assign half     = 6'd1 << stage_ff;
   assign low_mask = 5'(half - 6'd1);
   assign q        = bfly_ff & low_mask;
   assign p        = {bfly_ff & ~low_mask, 1'b0} | {1'b0, q};
   assign p2       = p | half;
   assign ra       = (stage_ff == 3'd0) ? bit_rev(p, lg) : p;
   assign rb       = (stage_ff == 3'd0) ? bit_rev(p2, lg) : p2;

   assign bfly_last  = ({1'b0, bfly_ff} == 6'((n >> 1) - 7'd1));
   assign stage_last = (stage_ff == lg - 3'd1);
   assign out_last   = ({1'b0, oidx_ff} == 7'(n - 7'd1));
   assign req_ready  = (state_ff == S_LOAD);
   assign accept     = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      stage_in = stage_ff;
      bfly_in  = bfly_ff;
      oidx_in  = oidx_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (count_ff + 7'd1 >= n) begin
                  count_in = '0;
                  stage_in = '0;
                  bfly_in  = '0;
                  state_in = S_RD;
               end else begin
                  count_in = count_ff + 7'd1;
               end
            end
         end
         S_RD:  state_in = S_MUL;
         S_MUL: state_in = S_TW;
         S_TW:  state_in = S_WP;
         S_WP:  state_in = S_WQ;
         S_WQ: begin
            if (!bfly_last) begin
               bfly_in  = bfly_ff + 5'd1;
               state_in = S_RD;
            end else if (!stage_last) begin
               bfly_in  = '0;
               stage_in = stage_ff + 3'd1;
               state_in = S_RD;
            end else begin
               oidx_in  = '0;
               state_in = S_ORD;
            end
         end
         S_ORD: state_in = S_OLD;
         S_OLD: begin
            if (out_free) begin
               oidx_in  = oidx_ff + 6'd1;
               state_in = out_last ? S_LOAD : S_ORD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         stage_ff   <= '0;
         bfly_ff    <= '0;
         oidx_ff    <= '0;
         inverse_ff <= 1'b0;
         log_ff     <= 3'd6;
         center_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         stage_ff <= stage_in;
         bfly_ff  <= bfly_in;
         oidx_ff  <= oidx_in;
         // register writes; unknown indexes are dropped
         if (csr_valid) begin
            if (csr_index == REG_INVERSE)  inverse_ff <= csr_data[0];
            if (csr_index == REG_LOG_SIZE) log_ff     <= csr_data[2:0];
            if (csr_index == REG_CENTER)   center_ff  <= csr_data[0];
         end
      end
   end

   // command outputs
   always_comb begin
      cmd           = '0;
      cmd.load_we   = accept;
      cmd.load_addr = count_ff[AddrBits-1:0];
      cmd.rd_en     = (state_ff == S_RD) || (state_ff == S_ORD);
      cmd.rd_bank   = (state_ff == S_ORD) ? lg[0] : stage_ff[0];
      cmd.rd_addr_a = (state_ff == S_ORD) ? oidx_ff : ra;
      cmd.rd_addr_b = rb;
      // centering before a forward transform, on odd original indexes
      cmd.neg_a     = center_ff && !inverse_ff && (stage_ff == 3'd0) && ra[0];
      cmd.neg_b     = center_ff && !inverse_ff && (stage_ff == 3'd0) && rb[0];
      cmd.mul_en    = (state_ff == S_MUL);
      cmd.tw_en     = (state_ff == S_TW);
      cmd.wr_p      = (state_ff == S_WP);
      cmd.wr_q      = (state_ff == S_WQ);
      cmd.wr_bank   = ~stage_ff[0];
      cmd.wr_addr_p = p;
      cmd.wr_addr_q = p2;
      cmd.tw_index  = 5'(q << (3'd5 - stage_ff));
      cmd.inverse   = inverse_ff;
      cmd.center    = center_ff;
      cmd.log_size  = lg;
      cmd.out_load  = (state_ff == S_OLD) && out_free;
      cmd.out_last  = out_last;
      cmd.out_odd   = oidx_ff[0];
   end

endmodule

### rtl/r2fft_dp.sv
// ----------------------------------------------------------------------------
// r2fft_dp
// Datapath: two ping-pong sample banks, butterfly unit and result register.
// ----------------------------------------------------------------------------
module r2fft_dp import r2fft_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   input  logic signed [SampleBits-1:0]  sample_real,
   input  logic signed [SampleBits-1:0]  sample_imag,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output store_type                     bin_real,
   output store_type                     bin_imag,
   output logic                          frame_last,
   output logic                          out_free
);

   logic [2*StoreBits-1:0] bank0_mem [MaxPoints];
   logic [2*StoreBits-1:0] bank1_mem [MaxPoints];
   logic [2*StoreBits-1:0] rda_ff, rdb_ff;

   store_type   a_r, a_i, b_r, b_i;
   store_type   r1_ff, i1_ff, tr_ff, ti_ff;
   twiddle_type w;
   logic signed [ProdBits-1:0] prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [ProdBits:0]   sum_r, sum_i;
   logic                       wr_en;
   addr_type                   wr_addr;
   logic [2*StoreBits-1:0]     wr_data;
   store_type                  o_r, o_i;
   logic signed [StoreBits:0]  ext_r, ext_i, bias;
   logic                       valid_ff;
   store_type                  bin_real_ff, bin_imag_ff;
   logic                       last_ff;

   // butterfly write port
   assign wr_en   = cmd.wr_p || cmd.wr_q;
   assign wr_addr = cmd.wr_p ? cmd.wr_addr_p : cmd.wr_addr_q;
   assign wr_data = cmd.wr_p ? {StoreBits'(r1_ff + tr_ff), StoreBits'(i1_ff + ti_ff)}
                             : {StoreBits'(r1_ff - tr_ff), StoreBits'(i1_ff - ti_ff)};

   // bank 0 takes loads and odd-stage results
   always_ff @(posedge clock) begin
      if (cmd.load_we)
         bank0_mem[cmd.load_addr] <= {StoreBits'(sample_real), StoreBits'(sample_imag)};
      else if (wr_en && !cmd.wr_bank)
         bank0_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en && cmd.wr_bank) bank1_mem[wr_addr] <= wr_data;
   end

   // registered two-address read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rda_ff <= cmd.rd_bank ? bank1_mem[cmd.rd_addr_a] : bank0_mem[cmd.rd_addr_a];
         rdb_ff <= cmd.rd_bank ? bank1_mem[cmd.rd_addr_b] : bank0_mem[cmd.rd_addr_b];
      end
   end

   assign a_r = cmd.neg_a ? -store_type'(rda_ff[2*StoreBits-1:StoreBits])
                          : store_type'(rda_ff[2*StoreBits-1:StoreBits]);
   assign a_i = cmd.neg_a ? -store_type'(rda_ff[StoreBits-1:0])
                          : store_type'(rda_ff[StoreBits-1:0]);
   assign b_r = cmd.neg_b ? -store_type'(rdb_ff[2*StoreBits-1:StoreBits])
                          : store_type'(rdb_ff[2*StoreBits-1:StoreBits]);
   assign b_i = cmd.neg_b ? -store_type'(rdb_ff[StoreBits-1:0])
                          : store_type'(rdb_ff[StoreBits-1:0]);
   assign w   = twiddle(cmd.tw_index, cmd.inverse);

   // complex multiply, then round back to store scale
   assign sum_r = (ProdBits+1)'(prr_ff) - (ProdBits+1)'(pii_ff)
                + ((ProdBits+1)'(1) <<< (RoundShift-1));
   assign sum_i = (ProdBits+1)'(pri_ff) + (ProdBits+1)'(pir_ff)
                + ((ProdBits+1)'(1) <<< (RoundShift-1));

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         r1_ff  <= a_r;
         i1_ff  <= a_i;
         prr_ff <= b_r * w.wr;
         pii_ff <= b_i * w.wi;
         pri_ff <= b_r * w.wi;
         pir_ff <= b_i * w.wr;
      end
      if (cmd.tw_en) begin
         tr_ff <= StoreBits'(sum_r >>> RoundShift);
         ti_ff <= StoreBits'(sum_i >>> RoundShift);
      end
   end

   // unload: inverse scaling by N with rounding, then centering
   assign bias  = (StoreBits+1)'(1) <<< (cmd.log_size - 3'd1);
   assign ext_r = (StoreBits+1)'(store_type'(rda_ff[2*StoreBits-1:StoreBits]));
   assign ext_i = (StoreBits+1)'(store_type'(rda_ff[StoreBits-1:0]));
   always_comb begin
      if (cmd.inverse) begin
         o_r = StoreBits'((ext_r + bias) >>> cmd.log_size);
         o_i = StoreBits'((ext_i + bias) >>> cmd.log_size);
         if (cmd.center && cmd.out_odd) begin
            o_r = -o_r;
            o_i = -o_i;
         end
      end else begin
         o_r = StoreBits'(ext_r);
         o_i = StoreBits'(ext_i);
      end
   end

   // result register
   assign out_free = !valid_ff || rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         bin_real_ff <= o_r;
         bin_imag_ff <= o_i;
         last_ff     <= cmd.out_last;
      end
   end

   assign rsp_valid  = valid_ff;
   assign bin_real   = bin_real_ff;
   assign bin_imag   = bin_imag_ff;
   assign frame_last = last_ff;

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the radix-2 FFT frame by frame: samples are collected per frame, a
// local fixed-point FFT works out the bins, and every output bin is compared.
// ----------------------------------------------------------------------------
module tb;
   import r2fft_pkg::*;

   typedef struct {
      logic signed [StoreBits-1:0] re;
      logic signed [StoreBits-1:0] im;
      logic                        last;
   } bin_item_type;

   typedef struct {
      logic signed [SampleBits-1:0] re;
      logic signed [SampleBits-1:0] im;
   } sample_type;

   logic clock;
   logic reset;

   r2fft_req_if req_chan ();
   r2fft_rsp_if rsp_chan ();
   r2fft_csr_if csr_chan ();

   radix2_complex_fft i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // local register copies and frame store
   logic        cfg_inverse;
   logic [2:0]  cfg_log_size;
   logic        cfg_center;
   longint      frame_re [MaxPoints];
   longint      frame_im [MaxPoints];
   int          fill_count;

   bin_item_type expected_bins [$];
   int  errors;
   int  bins_seen;
   int  frames_done;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("timeout after %0t", $realtime);
      $display("status: fail");
      $finish;
   end

   // floor((x + 2^(s-1)) / 2^s)
   function automatic longint rshift_round(longint x, int s);
      if (s == 0) return x;
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint wrap24(longint x);
      logic signed [StoreBits-1:0] t;
      t = x[StoreBits-1:0];
      return longint'(t);
   endfunction

   function automatic longint rom_cos(int k);
      int tbl [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                       23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
      return tbl[k];
   endfunction

   // transform the collected frame and queue its bins
   task automatic predict_frame(int lg);
      int     n;
      int     j;
      int     half;
      int     k;
      int     p2;
      longint t;
      longint wr;
      longint wi;
      longint s;
      longint tr;
      longint ti;
      longint r1;
      longint i1;
      bin_item_type b;
      n = 1 << lg;
      if (cfg_center && !cfg_inverse)
         for (int i = 1; i < n; i += 2) begin
            frame_re[i] = wrap24(-frame_re[i]);
            frame_im[i] = wrap24(-frame_im[i]);
         end
      for (int i = 0; i < n; i++) begin
         j = 0;
         for (int b2 = 0; b2 < lg; b2++) j = (j << 1) | ((i >> b2) & 1);
         if (i < j) begin
            t = frame_re[i]; frame_re[i] = frame_re[j]; frame_re[j] = t;
            t = frame_im[i]; frame_im[i] = frame_im[j]; frame_im[j] = t;
         end
      end
      half = 1;
      while (half < n) begin
         for (int q = 0; q < half; q++) begin
            k = q * (32 / half);
            wr = (k <= 16) ? rom_cos(k) : -rom_cos(32 - k);
            s  = (k <= 16) ? rom_cos(16 - k) : rom_cos(k - 16);
            wi = cfg_inverse ? s : -s;
            for (int p = q; p < n; p += 2 * half) begin
               p2 = p + half;
               r1 = frame_re[p];
               i1 = frame_im[p];
               tr = rshift_round(frame_re[p2] * wr - frame_im[p2] * wi, RoundShift);
               ti = rshift_round(frame_re[p2] * wi + frame_im[p2] * wr, RoundShift);
               frame_re[p2] = wrap24(r1 - tr);
               frame_im[p2] = wrap24(i1 - ti);
               frame_re[p]  = wrap24(r1 + tr);
               frame_im[p]  = wrap24(i1 + ti);
            end
         end
         half = half << 1;
      end
      if (cfg_inverse) begin
         for (int i = 0; i < n; i++) begin
            frame_re[i] = rshift_round(frame_re[i], lg);
            frame_im[i] = rshift_round(frame_im[i], lg);
         end
         if (cfg_center)
            for (int i = 1; i < n; i += 2) begin
               frame_re[i] = wrap24(-frame_re[i]);
               frame_im[i] = wrap24(-frame_im[i]);
            end
      end
      for (int i = 0; i < n; i++) begin
         b.re   = frame_re[i][StoreBits-1:0];
         b.im   = frame_im[i][StoreBits-1:0];
         b.last = (i == n - 1);
         expected_bins.push_back(b);
      end
   endtask

   function automatic int active_log();
      if (cfg_log_size < 1) return 1;
      if (cfg_log_size > LogMaxPoints) return LogMaxPoints;
      return int'(cfg_log_size);
   endfunction

   // store one accepted sample; frame completes when the count reaches N
   task automatic accept_sample(sample_type smp);
      frame_re[fill_count % MaxPoints] = longint'(smp.re);
      frame_im[fill_count % MaxPoints] = longint'(smp.im);
      fill_count++;
      if (fill_count >= (1 << active_log())) begin
         predict_frame(active_log());
         fill_count = 0;
         frames_done++;
      end
   endtask

   // one register write, then the channel goes idle again
   task automatic write_reg(logic [CsrIdxBits-1:0] idx, logic [CsrDataBits-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      case (idx)
         REG_INVERSE:  cfg_inverse  = val[0];
         REG_LOG_SIZE: cfg_log_size = val[2:0];
         REG_CENTER:   cfg_center   = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // one sample item with the sender's idle gaps
   task automatic send_sample(sample_type smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.sample_real <= smp.re;
      req_chan.sample_imag <= smp.im;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      accept_sample(smp);
   endtask

   task automatic stop_sending();
      req_chan.valid <= 1'b0;
   endtask

   // idle until every queued bin has come out, plus the block's pipeline tail
   task automatic drain();
      stop_sending();
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_mode(logic inv, logic [2:0] lg, logic cen);
      write_reg(REG_INVERSE, {7'd0, inv});
      write_reg(REG_LOG_SIZE, {5'd0, lg});
      write_reg(REG_CENTER, {7'd0, cen});
   endtask

   function automatic sample_type rand_sample(int kind);
      sample_type s;
      case (kind)
         0: begin s.re = 16'sh7fff; s.im = 16'sh8000; end
         1: begin
            s.re = 16'(int'($urandom_range(255)) - 128);
            s.im = 16'(int'($urandom_range(255)) - 128);
         end
         default: begin s.re = 16'($urandom); s.im = 16'($urandom); end
      endcase
      return s;
   endfunction

   // result side: random stalls, long hold-off, field checks
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            bins_seen++;
            if (expected_bins.size() == 0) begin
               $display("%0t: unexpected bin re=%0d im=%0d", $realtime,
                        rsp_chan.bin_real, rsp_chan.bin_imag);
               errors++;
            end else begin
               bin_item_type e;
               e = expected_bins.pop_front();
               if (e.re !== rsp_chan.bin_real || e.im !== rsp_chan.bin_imag ||
                   e.last !== rsp_chan.frame_last) begin
                  $display("%0t: bin mismatch expected re=%0d im=%0d last=%0b got re=%0d im=%0d last=%0b",
                           $realtime, e.re, e.im, e.last, rsp_chan.bin_real,
                           rsp_chan.bin_imag, rsp_chan.frame_last);
                  errors++;
               end
            end
         end
      end
   end

   // directed rows: mode, then one frame of samples of the given kind
   typedef struct {
      logic       inv;
      logic [2:0] lg;
      logic       cen;
      int         kind;
   } dir_row_type;

   dir_row_type dir_rows [8] = '{
      '{1'b0, 3'd1, 1'b0, 0}, '{1'b1, 3'd1, 1'b1, 0}, '{1'b0, 3'd0, 1'b1, 2},
      '{1'b0, 3'd7, 1'b0, 1}, '{1'b1, 3'd2, 1'b0, 2}, '{1'b0, 3'd3, 1'b1, 2},
      '{1'b1, 3'd3, 1'b1, 0}, '{1'b0, 3'd2, 1'b0, 2}
   };

   initial begin
      int  n;
      int  sent;
      int  reps;
      sample_type smp;
      errors = 0; bins_seen = 0; frames_done = 0; fill_count = 0; hold_cycles = 0;
      send_idle_pct = 0; recv_idle_pct = 0;
      cfg_inverse = 1'b0; cfg_log_size = 3'd6; cfg_center = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0; req_chan.sample_real = '0; req_chan.sample_imag = '0;
      csr_chan.valid = 1'b0; csr_chan.index = '0; csr_chan.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: the first frame runs at reset size with an impulse,
      // so all bins equal the first sample
      for (int i = 0; i < 64; i++) begin
         smp.re = (i == 0) ? 16'sd1000 : 16'sd0;
         smp.im = '0;
         send_sample(smp);
      end
      drain();
      // an unknown index must be ignored
      write_reg(8'd9, 8'hff);

      // directed part: extremes, clamped sizes, both directions, centering
      foreach (dir_rows[r]) begin
         set_mode(dir_rows[r].inv, dir_rows[r].lg, dir_rows[r].cen);
         n = 1 << active_log();
         for (int i = 0; i < n; i++) begin
            smp = rand_sample(dir_rows[r].kind);
            if (dir_rows[r].kind == 0 && i[0]) begin smp.re = 16'sh8000; smp.im = 16'sh7fff; end
            send_sample(smp);
         end
         drain();
      end

      // random part in three idling phases; small sizes dominate
      sent = 0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 82 : 0;
         recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 28 : 0;
         for (int f = 0; f < 4; f++) begin
            set_mode(1'($urandom_range(1)), ($urandom_range(9) == 0) ? 3'd6 :
                     3'($urandom_range(5)), 1'($urandom_range(1)));
            n = 1 << active_log();
            reps = 1;
            // long hold-off on the result side while two frames of samples
            // keep coming, so the input stalls behind the held results
            if (ph == 2 && f == 3) begin
               hold_cycles = 600;
               reps = 2;
            end
            for (int i = 0; i < reps * n; i++) begin
               smp = rand_sample($urandom_range(2) == 0 ? int'($urandom_range(1)) : 2);
               send_sample(smp);
               sent++;
            end
            drain();
         end
      end

      $display("ran %0d frames, %0d random samples, %0d bins checked", frames_done,
               sent, bins_seen);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### files.f
rtl/r2fft_pkg.sv
rtl/r2fft_req_if.sv
rtl/r2fft_rsp_if.sv
rtl/r2fft_csr_if.sv
rtl/r2fft_ctrl.sv
rtl/r2fft_dp.sv
rtl/radix2_complex_fft.sv
verif/tb.sv
